// ----- rtl/rsrd_pkg.sv -----
package rsrd_pkg;

	// default chain length
	localparam int unsigned MAX_CHIPS_DEF = 3;

	// register index, taken from paddr[2]
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_CHIPS = 1'b1;

	// request kinds
	localparam logic KIND_SET = 1'b0;
	localparam logic KIND_GET = 1'b1;

	// chip modes
	localparam logic CHIP_DUMMY = 1'b0; // dummy byte ahead of each data byte
	localparam logic CHIP_PLAIN = 1'b1; // plain shift register latch

	typedef struct packed {
		logic       kind;
		logic [4:0] relay_number;
		logic       value;
	} req_word_t;

	typedef struct packed {
		logic accepted;
		logic relay_state;
		logic shift_valid;
		logic shift_bit;
		logic last;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DUMMY,
		ST_DATA
	} seq_state_t;

	// sequencer to datapath
	typedef struct packed {
		logic busy;  // a shift run is under way
		logic emit;  // a serial word is due this cycle
		logic dummy; // it is a dummy bit
		logic shift; // rotate the chain by one bit
		logic last;  // final word of the run
	} seq_ctrl_t;

endpackage

// ----- rtl/rsrd_cell.sv -----
module rsrd_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       shift_in,
	input  logic       wr_en,
	input  logic [2:0] wr_pos,
	input  logic       wr_val,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	// one shadow byte; shifts towards bit 0, refills from the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (shift_en) begin
			byte_q <= {shift_in, byte_q[7:1]};
		end else if (wr_en) begin
			byte_q[wr_pos] <= wr_val;
		end
	end

	assign q = byte_q;

endmodule

// ----- rtl/rsrd_seq.sv -----
module rsrd_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  advance,
	input  logic                  mode,
	input  logic [1:0]            n_chips,
	output rsrd_pkg::seq_ctrl_t   ctrl
);

	rsrd_pkg::seq_state_t state_q, state_d;
	logic [2:0] bit_q;
	logic [1:0] byte_q;
	logic       byte_end;
	logic       run_end;

	assign byte_end = (bit_q == 3'd7);
	assign run_end  = byte_end && (byte_q == n_chips - 2'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rsrd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (mode == rsrd_pkg::CHIP_DUMMY) ?
						rsrd_pkg::ST_DUMMY : rsrd_pkg::ST_DATA;
				end
			end
			rsrd_pkg::ST_DUMMY: begin
				if (advance && byte_end) begin
					state_d = rsrd_pkg::ST_DATA;
				end
			end
			rsrd_pkg::ST_DATA: begin
				if (advance && byte_end) begin
					if (run_end) begin
						state_d = rsrd_pkg::ST_IDLE;
					end else if (mode == rsrd_pkg::CHIP_DUMMY) begin
						state_d = rsrd_pkg::ST_DUMMY;
					end else begin
						state_d = rsrd_pkg::ST_DATA;
					end
				end
			end
			default: state_d = rsrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			rsrd_pkg::ST_DUMMY: begin
				ctrl.busy  = 1'b1;
				ctrl.emit  = 1'b1;
				ctrl.dummy = 1'b1;
			end
			rsrd_pkg::ST_DATA: begin
				ctrl.busy  = 1'b1;
				ctrl.emit  = 1'b1;
				ctrl.shift = advance;
				ctrl.last  = run_end;
			end
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsrd_pkg::ST_IDLE;
			bit_q   <= 3'd0;
			byte_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (start) begin
				bit_q  <= 3'd0;
				byte_q <= 2'd0;
			end else if (advance && state_q != rsrd_pkg::ST_IDLE) begin
				bit_q <= bit_q + 3'd1;
				if (state_q == rsrd_pkg::ST_DATA && byte_end) begin
					byte_q <= byte_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/relay_shift_register_driver.sv -----
// Relay shift register driver.
// Request channel (req_valid / req_stall / req) takes one word at a time:
// a set writes one relay bit of the shadow chain and then plays the whole
// chain out serially, a get returns the stored relay bit.
// Response channel (rsp_valid / rsp_stall / rsp) carries one word per
// serial clock; the final word of every run has last set.
// A get or a rejected number answers in the cycle after the request is
// taken; the first serial word of a set passes the sequencer state register
// and then the output register. A set holds the block for its whole run,
// one serial bit per cycle while the response is not stalled, from the
// rotating chain of byte cells, with a dummy byte ahead of each data byte
// in dummy-byte mode; a get or a rejected number does not hold the block.
// Requests are stalled while a run is in progress or the output register
// is held. A stalled response holds the output register and freezes the
// chain and its counters; nothing is lost.
// Reset clears the shadow bytes (all relays off), selects dummy-byte mode
// and a single chip.
// Registers on the APB port: 0x0 chip mode, 0x4 number of chips
// (1..MAX_CHIPS, taken from pwdata[1:0], other values ignored).
module relay_shift_register_driver #(
	parameter int unsigned MAX_CHIPS = rsrd_pkg::MAX_CHIPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  rsrd_pkg::req_word_t req,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsrd_pkg::rsp_word_t rsp,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration
	logic       mode_q;
	logic [1:0] chips_q;
	logic       cfg_wr;
	logic [1:0] cnt_wdata;

	// request decode
	logic       req_take;
	logic [4:0] n;
	logic       num_ok;
	logic [1:0] idx;
	logic [2:0] pos;
	logic       get_bit;
	logic       set_start;

	// output register
	logic                rsp_valid_q;
	rsrd_pkg::rsp_word_t rsp_q;
	logic                load_ok;
	logic                state_q; // relay state reported during a run

	// chain
	logic [7:0]          cell_q [MAX_CHIPS];
	logic [MAX_CHIPS-1:0] sin;
	rsrd_pkg::seq_ctrl_t ctrl;

	// ---------------------------------------------------------------
	// Config registers, decoded on paddr[2] only
	// ---------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign cnt_wdata = pwdata[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rsrd_pkg::CHIP_DUMMY;
			chips_q <= 2'd1;
		end else if (cfg_wr) begin
			case (paddr[2])
				rsrd_pkg::REG_MODE: mode_q <= pwdata[0];
				rsrd_pkg::REG_CHIPS: begin
					// out-of-range counts are dropped
					if (cnt_wdata != 2'd0 && 32'(cnt_wdata) <= MAX_CHIPS) begin
						chips_q <= cnt_wdata;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rsrd_pkg::REG_MODE:  prdata = {31'd0, mode_q};
			rsrd_pkg::REG_CHIPS: prdata = {30'd0, chips_q};
			default:             prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: one output register; the chain only moves when it
	// can take a word.
	// ---------------------------------------------------------------
	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign req_stall = ctrl.busy || !load_ok;
	assign req_take  = req_valid && !req_stall;

	// ---------------------------------------------------------------
	// Relay number decode. n = number - 1; chip group n/8 counts from
	// the far end of the chain, bit within byte is n mod 8, mirrored
	// for plain latches.
	// ---------------------------------------------------------------
	assign n      = req.relay_number - 5'd1;
	assign num_ok = (req.relay_number != 5'd0) &&
		(req.relay_number <= {chips_q, 3'b000});
	assign idx    = chips_q - 2'd1 - n[4:3];
	assign pos    = (mode_q == rsrd_pkg::CHIP_PLAIN) ? (3'd7 - n[2:0]) : n[2:0];

	always_comb begin
		get_bit = 1'b0;
		for (int i = 0; i < int'(MAX_CHIPS); i++) begin
			if (32'(idx) == 32'(i)) begin
				get_bit = cell_q[i][pos];
			end
		end
	end

	assign set_start = req_take && num_ok && (req.kind == rsrd_pkg::KIND_SET);

	// ---------------------------------------------------------------
	// Chain of byte cells. In data bits the used chain rotates one bit a
	// cycle while the output can load: cell 0 bit 0 goes out and wraps
	// round to the top of the last used cell, so a full run restores it.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < int'(MAX_CHIPS); i++) begin : g_cell
		logic in_use;
		logic wr_hit;

		if (i == int'(MAX_CHIPS) - 1) begin : g_end
			assign sin[i] = cell_q[0][0];
		end else begin : g_mid
			assign sin[i] = (32'(chips_q) == 32'(i + 1)) ?
				cell_q[0][0] : cell_q[i+1][0];
		end

		assign in_use = 32'(chips_q) > 32'(i);
		assign wr_hit = set_start && (32'(idx) == 32'(i));

		rsrd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (ctrl.shift && in_use),
			.shift_in (sin[i]),
			.wr_en    (wr_hit),
			.wr_pos   (pos),
			.wr_val   (req.value),
			.q        (cell_q[i])
		);
	end

	rsrd_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (set_start),
		.advance (load_ok),
		.mode    (mode_q),
		.n_chips (chips_q),
		.ctrl    (ctrl)
	);

	// ---------------------------------------------------------------
	// Output register. A set loads nothing when taken; its first
	// serial word follows from the sequencer.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((req_take && !set_start) || (ctrl.emit && load_ok)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_start) begin
			state_q <= req.value;
		end
		if (req_take && !set_start) begin
			// get or rejected number: single word
			rsp_q.accepted    <= num_ok;
			rsp_q.relay_state <= num_ok && get_bit;
			rsp_q.shift_valid <= 1'b0;
			rsp_q.shift_bit   <= 1'b0;
			rsp_q.last        <= 1'b1;
		end else if (ctrl.emit && load_ok) begin
			rsp_q.accepted    <= 1'b1;
			rsp_q.relay_state <= state_q;
			rsp_q.shift_valid <= 1'b1;
			rsp_q.shift_bit   <= !ctrl.dummy && cell_q[0][0];
			rsp_q.last        <= ctrl.last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
